@@ sv/hbs_pkg.sv @@
// Shared types, register codes and constants of the heightmap bilinear sampler.
package hbs_pkg;

	localparam int unsigned GRID_DEF       = 129;
	localparam int unsigned BANK_DEPTH_DEF = ((GRID_DEF + 1) / 2) * ((GRID_DEF + 1) / 2);
	localparam int unsigned IDX_W          = 15;
	localparam int unsigned COORD_W        = 32;
	localparam int unsigned FRAC_W         = 16;
	localparam int unsigned IN_TDATA_W     = 144;
	localparam int unsigned OUT_TDATA_W    = 96;
	localparam int unsigned CFG_IDX_W      = 3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [COORD_W-1:0] SIGN_BIAS = 32'h8000_0000;
	localparam logic [COORD_W-1:0] SCALE_RST = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X   = 3'd0,
		REG_MIN_Y   = 3'd1,
		REG_MAX_X   = 3'd2,
		REG_MAX_Y   = 3'd3,
		REG_SCALE_X = 3'd4,
		REG_SCALE_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic query;
		logic in_tile;
		logic wr_ok;
	} ctl_t;

endpackage

@@ sv/hbs_ram.sv @@
// Generic single-port RAM with registered read data.
module hbs_ram #(
	parameter int unsigned WIDTH = hbs_pkg::COORD_W,
	parameter int unsigned DEPTH = hbs_pkg::BANK_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ sv/hbs_front.sv @@
// Front stages: bounds test, grid scaling, cell clamp and write index split.
module hbs_front #(
	parameter int unsigned GRID = hbs_pkg::GRID_DEF,
	localparam int unsigned CW = $clog2(GRID)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic                              in_op,
	input  logic [hbs_pkg::IDX_W-1:0]         in_index,
	input  logic [hbs_pkg::COORD_W-1:0]       in_height,
	input  logic signed [hbs_pkg::COORD_W-1:0] in_x,
	input  logic signed [hbs_pkg::COORD_W-1:0] in_y,
	input  logic signed [hbs_pkg::COORD_W-1:0] in_z,
	input  logic signed [hbs_pkg::COORD_W-1:0] min_x,
	input  logic signed [hbs_pkg::COORD_W-1:0] min_y,
	input  logic signed [hbs_pkg::COORD_W-1:0] max_x,
	input  logic signed [hbs_pkg::COORD_W-1:0] max_y,
	input  logic [hbs_pkg::COORD_W-1:0]       scale_x,
	input  logic [hbs_pkg::COORD_W-1:0]       scale_y,
	output hbs_pkg::ctl_t                     ctl_s3,
	output logic [CW-1:0]                     col_s3,
	output logic [CW-1:0]                     row_s3,
	output logic [hbs_pkg::FRAC_W-1:0]        tx_s3,
	output logic [hbs_pkg::FRAC_W-1:0]        ty_s3,
	output logic [hbs_pkg::COORD_W-1:0]       height_s3,
	output logic [hbs_pkg::COORD_W-1:0]       x_s3,
	output logic [hbs_pkg::COORD_W-1:0]       y_s3,
	output logic [hbs_pkg::COORD_W-1:0]       z_s3
);
	import hbs_pkg::*;

	localparam longint unsigned RecipL = 64'h1_0000_0000 / GRID;
	localparam logic [COORD_W-1:0] Recip    = 32'(RecipL);
	localparam logic [COORD_W-1:0] Cells    = 32'(GRID * GRID);
	localparam logic [COORD_W-1:0] ClampLim = 32'(GRID - 2);
	localparam logic [CW-1:0]      ClampMax = CW'(GRID - 2);
	localparam logic [IDX_W:0]     Grid16   = 16'(GRID);

	ctl_t               ctl_s1, ctl_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [COORD_W-1:0] height_s1, height_s2;
	logic [COORD_W-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [COORD_W-1:0] dx_s1, dy_s1;
	logic [47:0]        pu_s2, pv_s2;
	logic [IDX_W-1:0]   qest_s2;

	logic               inside_c;
	logic [63:0]        pu_c, pv_c;
	logic [46:0]        pq_c;
	logic [COORD_W-1:0] cxr, cyr, qg;
	logic [IDX_W:0]     rem;
	logic               fix;
	logic [CW-1:0]      col_c, row_c;

	assign inside_c = (in_x >= min_x) && (in_x <= max_x) && (in_y >= min_y) && (in_y <= max_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid   <= in_valid;
			ctl_s1.query   <= (in_op == OP_QUERY);
			ctl_s1.in_tile <= inside_c;
			ctl_s1.wr_ok   <= (32'(in_index) < Cells);
			ctl_s2         <= ctl_s1;
			ctl_s3         <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1    <= in_index;
			height_s1 <= in_height;
			x_s1      <= in_x;
			y_s1      <= in_y;
			z_s1      <= in_z;
			dx_s1     <= 32'(in_x - min_x);
			dy_s1     <= 32'(max_y - in_y);
		end
	end

	assign pu_c = 64'(dx_s1) * 64'(scale_x);
	assign pv_c = 64'(dy_s1) * 64'(scale_y);
	assign pq_c = 47'(idx_s1) * 47'(Recip);

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s2     <= pu_c[63:16];
			pv_s2     <= pv_c[63:16];
			qest_s2   <= pq_c[46:32];
			idx_s2    <= idx_s1;
			height_s2 <= height_s1;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
		end
	end

	assign cxr = pu_s2[47:16];
	assign cyr = pv_s2[47:16];
	assign qg  = 32'(qest_s2) * 32'(GRID);
	assign rem = {1'b0, idx_s2} - qg[IDX_W:0];
	assign fix = (rem >= Grid16);

	always_comb begin
		if (ctl_s2.query) begin
			col_c = (cxr > ClampLim) ? ClampMax : cxr[CW-1:0];
			row_c = (cyr > ClampLim) ? ClampMax : cyr[CW-1:0];
		end else begin
			col_c = fix ? CW'(rem - Grid16) : CW'(rem);
			row_c = fix ? CW'(qest_s2 + 15'd1) : CW'(qest_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s3    <= col_c;
			row_s3    <= row_c;
			tx_s3     <= pu_s2[15:0];
			ty_s3     <= pv_s2[15:0];
			height_s3 <= height_s2;
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			z_s3      <= z_s2;
		end
	end

	a_write_cell_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && !ctl_s3.query && ctl_s3.wr_ok
		|-> (32'(col_s3) < 32'(GRID)) && (32'(row_s3) < 32'(GRID)))
		else $error("write cell split out of grid");

	a_query_cell_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.query
		|-> (32'(col_s3) <= ClampLim) && (32'(row_s3) <= ClampLim))
		else $error("query cell not clamped");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s2.valid |=> ctl_s3.valid)
		else $error("word lost between front stages");

endmodule

@@ sv/hbs_store.sv @@
// Height store: four parity banks, corner addressing and corner reordering.
module hbs_store #(
	parameter int unsigned GRID = hbs_pkg::GRID_DEF,
	localparam int unsigned CW = $clog2(GRID)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  hbs_pkg::ctl_t               ctl_s3,
	input  logic [CW-1:0]               col_s3,
	input  logic [CW-1:0]               row_s3,
	input  logic [hbs_pkg::FRAC_W-1:0]  tx_s3,
	input  logic [hbs_pkg::FRAC_W-1:0]  ty_s3,
	input  logic [hbs_pkg::COORD_W-1:0] height_s3,
	input  logic [hbs_pkg::COORD_W-1:0] x_s3,
	input  logic [hbs_pkg::COORD_W-1:0] y_s3,
	input  logic [hbs_pkg::COORD_W-1:0] z_s3,
	output hbs_pkg::ctl_t               ctl_s4,
	output logic [hbs_pkg::COORD_W-1:0] h00,
	output logic [hbs_pkg::COORD_W-1:0] h10,
	output logic [hbs_pkg::COORD_W-1:0] h01,
	output logic [hbs_pkg::COORD_W-1:0] h11,
	output logic [hbs_pkg::FRAC_W-1:0]  tx_s4,
	output logic [hbs_pkg::FRAC_W-1:0]  ty_s4,
	output logic [hbs_pkg::COORD_W-1:0] x_s4,
	output logic [hbs_pkg::COORD_W-1:0] y_s4,
	output logic [hbs_pkg::COORD_W-1:0] z_s4
);
	import hbs_pkg::*;

	localparam int unsigned Half      = (GRID + 1) / 2;
	localparam int unsigned HW        = $clog2(Half);
	localparam int unsigned BankDepth = Half * Half;
	localparam int unsigned AW        = $clog2(BankDepth);

	logic [CW-1:0]      col_p1, row_p1;
	logic [HW-1:0]      bc [2];
	logic [HW-1:0]      br [2];
	logic [AW-1:0]      addr [4];
	logic [3:0]         we;
	logic               re;
	logic [COORD_W-1:0] rd [4];
	logic               pc_s4, pr_s4;

	assign col_p1 = CW'(col_s3 + CW'(1));
	assign row_p1 = CW'(row_s3 + CW'(1));

	always_comb begin
		bc[0] = ctl_s3.query ? HW'(col_p1 >> 1) : HW'(col_s3 >> 1);
		bc[1] = HW'(col_s3 >> 1);
		br[0] = ctl_s3.query ? HW'(row_p1 >> 1) : HW'(row_s3 >> 1);
		br[1] = HW'(row_s3 >> 1);
	end

	assign re = en && ctl_s3.valid && ctl_s3.query;

	for (genvar g = 0; g < 4; g++) begin : g_bank
		localparam int Pc = g % 2;
		localparam int Pr = g / 2;

		assign addr[g] = AW'(AW'(bc[Pc]) + AW'(br[Pr]) * AW'(Half));
		assign we[g]   = en && ctl_s3.valid && !ctl_s3.query && ctl_s3.wr_ok
			&& (col_s3[0] == 1'(Pc)) && (row_s3[0] == 1'(Pr));

		hbs_ram #(
			.WIDTH(COORD_W),
			.DEPTH(BankDepth)
		) u_bank (
			.clk  (clk),
			.we   (we[g]),
			.re   (re),
			.addr (addr[g]),
			.wdata(height_s3),
			.rdata(rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s4 <= col_s3[0];
			pr_s4 <= row_s3[0];
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			z_s4  <= z_s3;
		end
	end

	always_comb begin
		case ({pr_s4, pc_s4})
			2'b00: begin
				h00 = rd[0]; h10 = rd[1]; h01 = rd[2]; h11 = rd[3];
			end
			2'b01: begin
				h00 = rd[1]; h10 = rd[0]; h01 = rd[3]; h11 = rd[2];
			end
			2'b10: begin
				h00 = rd[2]; h10 = rd[3]; h01 = rd[0]; h11 = rd[1];
			end
			default: begin
				h00 = rd[3]; h10 = rd[2]; h01 = rd[1]; h11 = rd[0];
			end
		endcase
	end

	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we))
		else $error("more than one bank written");

	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(re && (|we)))
		else $error("bank read and write in one cycle");

endmodule

@@ sv/hbs_blend.sv @@
// Blend stages: two row blends along x, one blend along y, result register.
module hbs_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  hbs_pkg::ctl_t               ctl_s4,
	input  logic [hbs_pkg::COORD_W-1:0] h00,
	input  logic [hbs_pkg::COORD_W-1:0] h10,
	input  logic [hbs_pkg::COORD_W-1:0] h01,
	input  logic [hbs_pkg::COORD_W-1:0] h11,
	input  logic [hbs_pkg::FRAC_W-1:0]  tx_s4,
	input  logic [hbs_pkg::FRAC_W-1:0]  ty_s4,
	input  logic [hbs_pkg::COORD_W-1:0] x_s4,
	input  logic [hbs_pkg::COORD_W-1:0] y_s4,
	input  logic [hbs_pkg::COORD_W-1:0] z_s4,
	output logic                        out_valid,
	output logic [hbs_pkg::COORD_W-1:0] out_x,
	output logic [hbs_pkg::COORD_W-1:0] out_y,
	output logic [hbs_pkg::COORD_W-1:0] out_z,
	output logic                        out_inside
);
	import hbs_pkg::*;

	ctl_t               ctl_s5, ctl_s6, ctl_s7;
	logic [COORD_W-1:0] a0_s5, a1_s5, zx0_s6, zx1_s6, a_s7;
	logic signed [33:0] p0_s5, p1_s5, p2_s7;
	logic [FRAC_W-1:0]  ty_s5, ty_s6;
	logic [COORD_W-1:0] x_s5, y_s5, z_s5, x_s6, y_s6, z_s6, x_s7, y_s7, z_s7;

	logic [COORD_W-1:0] b00, b10, b01, b11;
	logic signed [32:0] d0, d1, d2;
	logic signed [16:0] tx17, ty17;
	logic signed [49:0] m0, m1, m2;
	logic signed [33:0] s0, s1, s2;

	assign b00  = h00 ^ SIGN_BIAS;
	assign b10  = h10 ^ SIGN_BIAS;
	assign b01  = h01 ^ SIGN_BIAS;
	assign b11  = h11 ^ SIGN_BIAS;
	assign tx17 = $signed({1'b0, tx_s4});
	assign d0   = $signed({1'b0, b10}) - $signed({1'b0, b00});
	assign d1   = $signed({1'b0, b11}) - $signed({1'b0, b01});
	assign m0   = d0 * tx17;
	assign m1   = d1 * tx17;

	assign s0 = $signed({2'b00, a0_s5}) + p0_s5;
	assign s1 = $signed({2'b00, a1_s5}) + p1_s5;

	assign ty17 = $signed({1'b0, ty_s6});
	assign d2   = $signed({1'b0, zx1_s6}) - $signed({1'b0, zx0_s6});
	assign m2   = d2 * ty17;

	assign s2 = $signed({2'b00, a_s7}) + p2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5    <= '0;
			ctl_s6    <= '0;
			ctl_s7    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			ctl_s5    <= ctl_s4;
			ctl_s6    <= ctl_s5;
			ctl_s7    <= ctl_s6;
			out_valid <= ctl_s7.valid && ctl_s7.query;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s5  <= b00;
			a1_s5  <= b01;
			p0_s5  <= m0[49:16];
			p1_s5  <= m1[49:16];
			ty_s5  <= ty_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			z_s5   <= z_s4;

			zx0_s6 <= 32'(s0);
			zx1_s6 <= 32'(s1);
			ty_s6  <= ty_s5;
			x_s6   <= x_s5;
			y_s6   <= y_s5;
			z_s6   <= z_s5;

			a_s7   <= zx0_s6;
			p2_s7  <= m2[49:16];
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			z_s7   <= z_s6;

			out_x      <= x_s7;
			out_y      <= y_s7;
			out_z      <= ctl_s7.in_tile ? (32'(s2) ^ SIGN_BIAS) : z_s7;
			out_inside <= ctl_s7.in_tile;
		end
	end

endmodule

@@ sv/heightmap_bilinear_sampler_unit.sv @@
// Top level of the heightmap bilinear sampler: config registers, stream ports, pipeline.
// Takes one word per cycle, write or query alike, and returns a query's result word from
// the blend stages after the front and store stages; a write returns no word. The rate
// is set by the height store, split into four banks by column and row parity so that the
// four corners of a cell are read together, one port per bank. A write uses one bank port
// in its cycle. The pipeline holds as a whole while a result word waits on m_axis_tready.
// Cells come up unwritten after reset; query only cells that were written.
module heightmap_bilinear_sampler_unit #(
	parameter int unsigned GRID = hbs_pkg::GRID_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// cell_index[14:0], cell_height[46:15], pos_x[78:47], pos_y[110:79], pos_z[142:111]
	input  logic [hbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [hbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// inside_res
	output logic                              m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hbs_pkg::COORD_W-1:0]       cfg_wdata
);
	import hbs_pkg::*;

	localparam int unsigned CW = $clog2(GRID);

	logic signed [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [COORD_W-1:0]        scale_x_q, scale_y_q;
	logic                      en;

	ctl_t               ctl_s3, ctl_s4;
	logic [CW-1:0]      col_s3, row_s3;
	logic [FRAC_W-1:0]  tx_s3, ty_s3, tx_s4, ty_s4;
	logic [COORD_W-1:0] height_s3, x_s3, y_s3, z_s3, x_s4, y_s4, z_s4;
	logic [COORD_W-1:0] h00, h10, h01, h11;
	logic [COORD_W-1:0] out_x, out_y, out_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q   <= '0;
			min_y_q   <= '0;
			max_x_q   <= '0;
			max_y_q   <= '0;
			scale_x_q <= SCALE_RST;
			scale_y_q <= SCALE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_X:   min_x_q   <= cfg_wdata;
				REG_MIN_Y:   min_y_q   <= cfg_wdata;
				REG_MAX_X:   max_x_q   <= cfg_wdata;
				REG_MAX_Y:   max_y_q   <= cfg_wdata;
				REG_SCALE_X: scale_x_q <= cfg_wdata;
				REG_SCALE_Y: scale_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tdata  = {out_z, out_y, out_x};

	hbs_front #(
		.GRID(GRID)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_index (s_axis_tdata[14:0]),
		.in_height(s_axis_tdata[46:15]),
		.in_x     (s_axis_tdata[78:47]),
		.in_y     (s_axis_tdata[110:79]),
		.in_z     (s_axis_tdata[142:111]),
		.min_x    (min_x_q),
		.min_y    (min_y_q),
		.max_x    (max_x_q),
		.max_y    (max_y_q),
		.scale_x  (scale_x_q),
		.scale_y  (scale_y_q),
		.ctl_s3   (ctl_s3),
		.col_s3   (col_s3),
		.row_s3   (row_s3),
		.tx_s3    (tx_s3),
		.ty_s3    (ty_s3),
		.height_s3(height_s3),
		.x_s3     (x_s3),
		.y_s3     (y_s3),
		.z_s3     (z_s3)
	);

	hbs_store #(
		.GRID(GRID)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s3   (ctl_s3),
		.col_s3   (col_s3),
		.row_s3   (row_s3),
		.tx_s3    (tx_s3),
		.ty_s3    (ty_s3),
		.height_s3(height_s3),
		.x_s3     (x_s3),
		.y_s3     (y_s3),
		.z_s3     (z_s3),
		.ctl_s4   (ctl_s4),
		.h00      (h00),
		.h10      (h10),
		.h01      (h01),
		.h11      (h11),
		.tx_s4    (tx_s4),
		.ty_s4    (ty_s4),
		.x_s4     (x_s4),
		.y_s4     (y_s4),
		.z_s4     (z_s4)
	);

	hbs_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s4    (ctl_s4),
		.h00       (h00),
		.h10       (h10),
		.h01       (h01),
		.h11       (h11),
		.tx_s4     (tx_s4),
		.ty_s4     (ty_s4),
		.x_s4      (x_s4),
		.y_s4      (y_s4),
		.z_s4      (z_s4),
		.out_valid (m_axis_tvalid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_inside(m_axis_tuser)
	);

endmodule

@@ test/tb_heightmap_bilinear_sampler_unit.sv @@
// Self-checking testbench of the heightmap bilinear sampler: stream stimulus, predictor, checker.
module tb_heightmap_bilinear_sampler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hbs_pkg::*;

	localparam int GRID           = GRID_DEF;
	localparam int CELLS          = GRID * GRID;
	localparam int IDX_SPAN       = 32767;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	localparam int Q_MIN          = 32'sh8000_0000;
	localparam int Q_MAX          = 32'sh7FFF_FFFF;
	localparam int Q_UNIT_EXT     = 32'sh0080_0000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        in_tile;
	} sample_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// cell_index[14:0], cell_height[46:15], pos_x[78:47], pos_y[110:79], pos_z[142:111]
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	// op
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// out_x[31:0], out_y[63:32], out_z[95:64]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// inside_res
	logic                   m_axis_tuser;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [COORD_W-1:0]     cfg_wdata;

	int          tile_min_x, tile_min_y, tile_max_x, tile_max_y;
	logic [31:0] scale_x_q, scale_y_q;
	logic [31:0] height_mem [CELLS];
	bit          cell_written [CELLS];
	sample_t     pending_samples [$];

	idle_t idle_mode;
	int    mismatches;
	int    quiet_cycles;
	int    n_writes, n_queries, n_inside, n_tiles;

	heightmap_bilinear_sampler_unit #(.GRID(GRID)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [15:0] t);
		return (a * (64'd65536 - 64'(t)) + b * 64'(t)) >> FRAC_W;
	endfunction

	function automatic sample_t sample_surface(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		sample_t     r;
		logic [31:0] off_x, off_y;
		logic [63:0] u, v, cx, cy, h00, h10, h01, h11, row0, row1, zz;
		r.x = x;
		r.y = y;
		r.z = z;
		r.in_tile = 1'b0;
		if ($signed(x) < tile_min_x || $signed(x) > tile_max_x ||
				$signed(y) < tile_min_y || $signed(y) > tile_max_y)
			return r;
		off_x = x - tile_min_x;
		off_y = tile_max_y - y;
		u = (64'(off_x) * 64'(scale_x_q)) >> FRAC_W;
		v = (64'(off_y) * 64'(scale_y_q)) >> FRAC_W;
		cx = u >> FRAC_W;
		cy = v >> FRAC_W;
		if (cx > GRID - 2)
			cx = GRID - 2;
		if (cy > GRID - 2)
			cy = GRID - 2;
		h00 = 64'(height_mem[cx + cy * GRID] ^ SIGN_BIAS);
		h10 = 64'(height_mem[cx + 1 + cy * GRID] ^ SIGN_BIAS);
		h01 = 64'(height_mem[cx + (cy + 1) * GRID] ^ SIGN_BIAS);
		h11 = 64'(height_mem[cx + 1 + (cy + 1) * GRID] ^ SIGN_BIAS);
		row0 = blend(h00, h10, u[15:0]);
		row1 = blend(h01, h11, u[15:0]);
		zz = blend(row0, row1, v[15:0]);
		r.z = zz[31:0] ^ SIGN_BIAS;
		r.in_tile = 1'b1;
		return r;
	endfunction

	function automatic bit sender_pause();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 58;
			IDLE_BOTH:   return $urandom_range(99) < 26;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] pick_in(int lo, int hi);
		longint span, r;
		if (hi < lo)
			return $urandom;
		span = longint'(hi) - longint'(lo);
		r = longint'({$urandom, $urandom} >> 1);
		return 32'(longint'(lo) + r % (span + 1));
	endfunction

	function automatic logic [31:0] rand_height();
		case ($urandom_range(7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic apply_word(input logic op, input logic [14:0] idx,
			input logic [31:0] h, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		sample_t s;
		if (op == OP_WRITE) begin
			n_writes++;
			if (idx < CELLS) begin
				height_mem[idx]   = h;
				cell_written[idx] = 1'b1;
			end
		end else begin
			n_queries++;
			s = sample_surface(x, y, z);
			if (s.in_tile)
				n_inside++;
			pending_samples.push_back(s);
		end
	endtask

	task automatic send_word(input logic op, input logic [14:0] idx,
			input logic [31:0] h, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while (sender_pause()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, z, y, x, h, idx};
		do @(posedge clk); while (!s_axis_tready);
		apply_word(op, idx, h, x, y, z);
		@(negedge clk);
	endtask

	task automatic write_cell(input int idx, input logic [31:0] h);
		send_word(OP_WRITE, 15'(idx), h, $urandom, $urandom, $urandom);
	endtask

	task automatic cover_cells(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] off_x, off_y;
		logic [63:0] u, v;
		int          cx, cy, idx;
		if ($signed(x) < tile_min_x || $signed(x) > tile_max_x ||
				$signed(y) < tile_min_y || $signed(y) > tile_max_y)
			return;
		off_x = x - tile_min_x;
		off_y = tile_max_y - y;
		u = ((64'(off_x) * 64'(scale_x_q)) >> FRAC_W) >> FRAC_W;
		v = ((64'(off_y) * 64'(scale_y_q)) >> FRAC_W) >> FRAC_W;
		cx = (u > GRID - 2) ? GRID - 2 : int'(u);
		cy = (v > GRID - 2) ? GRID - 2 : int'(v);
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 2; c++) begin
				idx = cx + c + (cy + r) * GRID;
				if (!cell_written[idx])
					write_cell(idx, rand_height());
			end
	endtask

	task automatic query(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		cover_cells(x, y);
		send_word(OP_QUERY, 15'($urandom_range(0, IDX_SPAN)), $urandom, x, y, z);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_tile(input int mnx, input int mny, input int mxx, input int mxy,
			input logic [31:0] sx, input logic [31:0] sy);
		reg_idx_t    r;
		logic [31:0] val;
		drain();
		r = r.first();
		repeat (r.num()) begin
			case (r)
				REG_MIN_X:   val = mnx;
				REG_MIN_Y:   val = mny;
				REG_MAX_X:   val = mxx;
				REG_MAX_Y:   val = mxy;
				REG_SCALE_X: val = sx;
				default:     val = sy;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= val;
			@(negedge clk);
			r = r.next();
		end
		cfg_we <= 1'b0;
		tile_min_x = mnx;
		tile_min_y = mny;
		tile_max_x = mxx;
		tile_max_y = mxy;
		scale_x_q  = sx;
		scale_y_q  = sy;
		n_tiles++;
	endtask

	task automatic random_tile();
		longint      lo_x, lo_y, ext_x, ext_y;
		int          mnx, mxx;
		logic [31:0] sx, sy;
		ext_x = $urandom_range(32'h0000_4000, 32'h0400_0000);
		ext_y = $urandom_range(32'h0000_4000, 32'h0400_0000);
		lo_x  = longint'($urandom_range(0, 32'h6000_0000)) - 64'sh4000_0000;
		lo_y  = longint'($urandom_range(0, 32'h6000_0000)) - 64'sh4000_0000;
		sx = 32'((64'(GRID - 1) << 32) / ext_x);
		sy = 32'((64'(GRID - 1) << 32) / ext_y);
		if ($urandom_range(3) == 0)
			sx = sx + (sx >> $urandom_range(3, 8));
		if ($urandom_range(3) == 0)
			sy = sy + (sy >> $urandom_range(3, 8));
		mnx = int'(lo_x);
		mxx = int'(lo_x + ext_x);
		if ($urandom_range(9) == 0) begin
			mnx = int'(lo_x + ext_x);
			mxx = int'(lo_x);
		end
		load_tile(mnx, int'(lo_y), mxx, int'(lo_y + ext_y), sx, sy);
	endtask

	task automatic random_item();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			write_cell($urandom_range(CELLS, IDX_SPAN), $urandom);
		else if (roll < 25)
			write_cell($urandom_range(0, CELLS - 1), rand_height());
		else if (roll < 85)
			query(pick_in(tile_min_x, tile_max_x), pick_in(tile_min_y, tile_max_y), $urandom);
		else if (roll < 92)
			query($urandom_range(1) ? tile_max_x : tile_min_x,
				$urandom_range(1) ? tile_max_y : tile_min_y, $urandom);
		else
			query($urandom, $urandom, $urandom);
	endtask

	task automatic test_preload_grid();
		idle_mode = IDLE_NONE;
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 2; c++) begin
				write_cell(c + r * GRID, rand_height());
				write_cell(CELLS - 1 - c - r * GRID, rand_height());
			end
	endtask

	task automatic test_reset_registers();
		query(32'h0000_0000, 32'h0000_0000, $urandom);
		query(32'h0000_0001, 32'h0000_0000, $urandom);
		query(32'h0000_0000, 32'hFFFF_FFFF, $urandom);
		query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_corner_extremes();
		load_tile(0, 0, Q_UNIT_EXT, Q_UNIT_EXT, Q_ONE, Q_ONE);
		write_cell(0, 32'h7FFF_FFFF);
		write_cell(1, 32'h8000_0000);
		write_cell(GRID, 32'h8000_0000);
		write_cell(GRID + 1, 32'h7FFF_FFFF);
		query(32'h0000_0000, Q_UNIT_EXT, $urandom);
		query(32'h0000_8000, Q_UNIT_EXT - 32'h8000, $urandom);
		query(32'h0000_FFFF, Q_UNIT_EXT - 32'hFFFF, $urandom);
		query(32'h0000_0001, Q_UNIT_EXT - 32'h0001, $urandom);
	endtask

	task automatic test_far_edge();
		query(Q_UNIT_EXT, 32'h0000_0000, $urandom);
		query(Q_UNIT_EXT, Q_UNIT_EXT, $urandom);
		write_cell(CELLS, $urandom);
		write_cell(IDX_SPAN, $urandom);
		query(Q_UNIT_EXT, 32'h0000_0000, $urandom);
		load_tile(0, 0, Q_UNIT_EXT, Q_UNIT_EXT, 32'h0001_0123, 32'h0001_0321);
		query(Q_UNIT_EXT, 32'h0000_0000, $urandom);
		query(Q_UNIT_EXT - 32'h0001, 32'h0000_0001, $urandom);
	endtask

	task automatic test_empty_bounds();
		load_tile(32'sh000A_0000, 32'sh0000_0000, 32'sh0005_0000, 32'sh0010_0000, Q_ONE, Q_ONE);
		query(32'h0007_0000, 32'h0007_0000, $urandom);
		query(32'h000A_0000, 32'h0000_0000, $urandom);
		query(32'h0005_0000, 32'h0010_0000, $urandom);
	endtask

	task automatic test_register_extremes();
		load_tile(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		query(Q_MIN, Q_MAX, $urandom);
		query(Q_MAX, Q_MIN, $urandom);
		query($urandom, $urandom, $urandom);
		load_tile(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 32'h0000_0000, 32'h0000_0000);
		query($urandom, $urandom, $urandom);
		query(Q_MAX, Q_MIN, $urandom);
	endtask

	task automatic test_random_traffic();
		idle_t m;
		m = m.first();
		repeat (m.num()) begin
			idle_mode = m;
			repeat (3) begin
				random_tile();
				repeat (11) random_item();
			end
			m = m.next();
		end
	endtask

	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: m_axis_tready <= $urandom_range(99) >= 58;
			IDLE_BOTH:     m_axis_tready <= $urandom_range(99) >= 26;
			default:       m_axis_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin : check_results
		sample_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected word x=%h y=%h z=%h inside=%b",
						$realtime, got.x, got.y, got.z, got.in_tile);
			end else begin
				want = pending_samples.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: mismatch exp x=%h y=%h z=%h inside=%b got x=%h y=%h z=%h inside=%b",
							$realtime, want.x, want.y, want.z, want.in_tile,
							got.x, got.y, got.z, got.in_tile);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no word moved for %0d cycles, %0d results outstanding",
					$realtime, WATCHDOG_LIMIT, pending_samples.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		idle_mode     = IDLE_NONE;
		mismatches    = 0;
		quiet_cycles  = 0;
		n_writes      = 0;
		n_queries     = 0;
		n_inside      = 0;
		n_tiles       = 0;
		tile_min_x    = 0;
		tile_min_y    = 0;
		tile_max_x    = 0;
		tile_max_y    = 0;
		scale_x_q     = SCALE_RST;
		scale_y_q     = SCALE_RST;
		for (int i = 0; i < CELLS; i++) begin
			height_mem[i]   = '0;
			cell_written[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_preload_grid();
		test_reset_registers();
		test_corner_extremes();
		test_far_edge();
		test_empty_bounds();
		test_register_extremes();
		test_random_traffic();
		drain();

		$display("Covered %0d writes and %0d queries (%0d inside the tile) over %0d register settings",
			n_writes, n_queries, n_inside, n_tiles);
		$display("Idle patterns: none, sender, receiver, both; %0d mismatches", mismatches);
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
sv/hbs_pkg.sv
sv/hbs_ram.sv
sv/hbs_front.sv
sv/hbs_store.sv
sv/hbs_blend.sv
sv/heightmap_bilinear_sampler_unit.sv
test/tb_heightmap_bilinear_sampler_unit.sv
